// File: rtl/mfcc_pkg.sv
// Package for the Modbus RTU frame checker: beat types, CRC constants
// and the byte-wide reflected CRC-16 update. No dependencies.
package mfcc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [3:0]  POS_MAX  = 4'd15;

   // byte positions of the captured fields
   localparam logic [3:0] POS_ADDR    = 4'd0;
   localparam logic [3:0] POS_VAL0_HI = 4'd3;
   localparam logic [3:0] POS_VAL0_LO = 4'd4;
   localparam logic [3:0] POS_VAL1_HI = 4'd5;
   localparam logic [3:0] POS_VAL1_LO = 4'd6;
   localparam logic [3:0] POS_VAL2_HI = 4'd9;
   localparam logic [3:0] POS_VAL2_LO = 4'd10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } mfcc_req_type;

   typedef struct packed {
      logic        crc_good;
      logic        too_short;
      logic [7:0]  device_address;
      logic [15:0] first_value;
      logic [15:0] second_value;
      logic [15:0] third_value;
   } mfcc_rsp_type;

   // one byte through the LSB-first CRC, eight bit steps unrolled
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/modbus_frame_crc_check_and_fields.sv
// Top level of the Modbus RTU frame checker: CRC-16 over the frame body,
// trailer compare and field capture by byte position. Uses mfcc_pkg.
//
// Usage:
//   req channel: one frame byte per beat, last_byte marks the frame's end.
//   rsp channel: one beat per frame, sent for the last byte only, with the
//     CRC verdict, the short-frame flag and the captured fields.
//   Every byte updates the frame state in the cycle it is accepted; the
//   result for a last byte sits in the output register in the cycle after
//   acceptance. One byte per cycle is taken, back to back, while req_stall
//   is low; the byte-wide CRC update is done in the accept cycle.
//   The two final bytes are held in a two-byte delay so the CRC only sees
//   bytes known not to be the trailer.
//   Reset (synchronous) clears the frame state to CRC 0xFFFF, position 0
//   and zero captures, and empties the output register.
//   While a result waits under rsp_stall, req_stall is raised; otherwise
//   bytes flow every cycle, also in the cycle a result is taken.
//   After each last byte the frame state returns to its reset values.
module modbus_frame_crc_check_and_fields (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mfcc_pkg::mfcc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mfcc_pkg::mfcc_rsp_type rsp_data
);
   import mfcc_pkg::*;

   logic [15:0]  crc_ff, crc_in;
   logic [7:0]   held0_ff, held0_in;
   logic [7:0]   held1_ff, held1_in;
   logic [3:0]   pos_ff, pos_in;
   logic [7:0]   addr_ff, addr_in;
   logic [15:0]  val0_ff, val0_in;
   logic [15:0]  val1_ff, val1_in;
   logic [15:0]  val2_ff, val2_in;
   logic         rsp_valid_ff, rsp_valid_in;
   mfcc_rsp_type rsp_data_ff, rsp_data_in;

   logic         accept;
   logic [15:0]  crc_now;
   logic [7:0]   addr_cap;
   logic [15:0]  val0_cap, val1_cap, val2_cap;
   logic         short_frame;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // byte two back can no longer belong to the trailer
      crc_now = (pos_ff >= 4'd2) ? crc_feed(crc_ff, held1_ff) : crc_ff;

      addr_cap = addr_ff;
      val0_cap = val0_ff;
      val1_cap = val1_ff;
      val2_cap = val2_ff;
      case (pos_ff)
         POS_ADDR:    addr_cap = req_data.data_byte;
         POS_VAL0_HI: val0_cap = {req_data.data_byte, val0_ff[7:0]};
         POS_VAL0_LO: val0_cap = {val0_ff[15:8], req_data.data_byte};
         POS_VAL1_HI: val1_cap = {req_data.data_byte, val1_ff[7:0]};
         POS_VAL1_LO: val1_cap = {val1_ff[15:8], req_data.data_byte};
         POS_VAL2_HI: val2_cap = {req_data.data_byte, val2_ff[7:0]};
         POS_VAL2_LO: val2_cap = {val2_ff[15:8], req_data.data_byte};
         default: ;
      endcase

      short_frame = (pos_ff < 4'd2);

      rsp_data_in.crc_good       = ~short_frame &&
                                   ({req_data.data_byte, held0_ff} == crc_now);
      rsp_data_in.too_short      = short_frame;
      rsp_data_in.device_address = addr_cap;
      rsp_data_in.first_value    = val0_cap;
      rsp_data_in.second_value   = val1_cap;
      rsp_data_in.third_value    = val2_cap;

      crc_in   = crc_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      pos_in   = pos_ff;
      addr_in  = addr_ff;
      val0_in  = val0_ff;
      val1_in  = val1_ff;
      val2_in  = val2_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            crc_in   = CRC_INIT;
            held0_in = '0;
            held1_in = '0;
            pos_in   = '0;
            addr_in  = '0;
            val0_in  = '0;
            val1_in  = '0;
            val2_in  = '0;
         end else begin
            crc_in   = crc_now;
            held0_in = req_data.data_byte;
            held1_in = held0_ff;
            pos_in   = (pos_ff < POS_MAX) ? pos_ff + 4'd1 : pos_ff;
            addr_in  = addr_cap;
            val0_in  = val0_cap;
            val1_in  = val1_cap;
            val2_in  = val2_cap;
         end
      end

      if (accept && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         held0_ff     <= '0;
         held1_ff     <= '0;
         pos_ff       <= '0;
         addr_ff      <= '0;
         val0_ff      <= '0;
         val1_ff      <= '0;
         val2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         pos_ff       <= pos_in;
         addr_ff      <= addr_in;
         val0_ff      <= val0_in;
         val1_ff      <= val1_in;
         val2_ff      <= val2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only on a last-byte beat
   always_ff @(posedge clock) begin
      if (accept && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
